[hw/rtl/bsb_pkg.sv]
// Shared types and constants for the 24-bit BMP stream binarizer.
package bsb_pkg;

	// Image size limits
	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 4096;

	// Header layout
	localparam int unsigned HDR_BYTES = 54;
	localparam int unsigned WIDTH_AT  = 18;
	localparam int unsigned HEIGHT_AT = 22;
	localparam int unsigned HCNT_W    = 6;

	// Field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned THR_W    = 10;
	localparam int unsigned SUM_W    = 10;
	localparam int unsigned POS_W    = 12;
	localparam logic [THR_W-1:0] THR_RESET = 10'd100;

	// Internal counter widths, derived from the limits
	localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HGT_W = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned ACT_W = $clog2(3 * MAX_WIDTH + 4);

	// Result kinds
	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_REJECT = 1'b1;

	// One input byte
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              start_of_file;
	} item_t;

	// One result item
	typedef struct packed {
		logic             kind;
		logic             pixel_on;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             last_pixel;
	} result_t;

endpackage

[hw/rtl/bsb_in_reg.sv]
// Input register stage: holds one accepted byte until the parser takes it.
module bsb_in_reg
	import bsb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t in_item,
	input  logic  consume,
	output logic  item_valid_s1,
	output item_t item_s1
);

	logic accept;

	// Stall while the held byte cannot move on this cycle
	assign in_stall = item_valid_s1 && !consume;
	assign accept   = in_valid && !in_stall;

	// Track occupancy of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (consume) begin
			item_valid_s1 <= 1'b0;
		end
	end

	// Capture the payload on each transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

endmodule

[hw/rtl/bsb_parser.sv]
// Header parse, row walk and threshold logic with the parse state registers.
module bsb_parser
	import bsb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             threshold_we,
	input  logic [THR_W-1:0] threshold_wdata,
	input  logic             item_valid_s1,
	input  item_t            item_s1,
	input  logic             out_free,
	output logic             consume,
	output logic             res_valid,
	output result_t          res
);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_PIXELS = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	// Parse state
	logic [THR_W-1:0]  threshold_q;
	logic [1:0]        phase_q, phase_d, phase_e;
	logic [HCNT_W-1:0] hcount_q, hcount_d, hcount_e;
	logic [31:0]       img_w_q, img_w_d, img_w_e;
	logic [31:0]       img_h_q, img_h_d, img_h_e;
	logic [ACT_W-1:0]  rbc_q, rbc_d, rbc_e;
	logic [HGT_W-1:0]  row_q, row_d, row_e;
	logic [WID_W-1:0]  col_q, col_d, col_e;
	logic [1:0]        pbi_q, pbi_d, pbi_e;
	logic [SUM_W-1:0]  psum_q, psum_d, psum_e;

	// Geometry fixed at the end of the header
	logic [ACT_W-1:0]  active_q, active_d;
	logic [ACT_W-1:0]  pad_m1_q, pad_m1_d;
	logic [WID_W-1:0]  w_m1_q, w_m1_d;
	logic [HGT_W-1:0]  h_m1_q, h_m1_d;

	// Step temporaries
	logic [1:0]        lane;
	logic [31:0]       byte_shifted;
	logic              dims_ok;
	logic [WID_W-1:0]  w_dim;
	logic [HGT_W-1:0]  h_dim;
	logic [ACT_W-1:0]  w_ext;
	logic [ACT_W-1:0]  active_c;
	logic [ACT_W-1:0]  padded_c;
	logic [SUM_W-1:0]  sum_c;
	logic              last_c;
	logic [31:0]       col_ext;
	logic [31:0]       row_ext;
	logic              emit;
	result_t           res_c;

	// Width or height check: positive and within the limit
	function automatic logic dim_ok(input logic [31:0] v, input logic [31:0] limit);
		dim_ok = (v != 32'd0) && !v[31] && (v <= limit);
	endfunction

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
		end else if (threshold_we) begin
			threshold_q <= threshold_wdata;
		end
	end

	// Start of file drops the current image and restarts at header byte 0
	always_comb begin
		if (item_s1.start_of_file) begin
			phase_e  = PH_HEADER;
			hcount_e = '0;
			img_w_e  = '0;
			img_h_e  = '0;
			rbc_e    = '0;
			row_e    = '0;
			col_e    = '0;
			pbi_e    = '0;
			psum_e   = '0;
		end else begin
			phase_e  = phase_q;
			hcount_e = hcount_q;
			img_w_e  = img_w_q;
			img_h_e  = img_h_q;
			rbc_e    = rbc_q;
			row_e    = row_q;
			col_e    = col_q;
			pbi_e    = pbi_q;
			psum_e   = psum_q;
		end
	end

	// Shared step arithmetic
	assign lane         = hcount_e[1:0] - 2'(WIDTH_AT);
	assign byte_shifted = {24'd0, item_s1.data_byte} << {lane, 3'b000};
	assign dims_ok      = dim_ok(img_w_e, 32'(MAX_WIDTH)) && dim_ok(img_h_e, 32'(MAX_HEIGHT));
	assign w_dim        = img_w_e[WID_W-1:0];
	assign h_dim        = img_h_e[HGT_W-1:0];
	assign w_ext        = ACT_W'(w_dim);
	assign active_c     = w_ext + (w_ext << 1);
	assign padded_c     = (active_c + ACT_W'(3)) & ~ACT_W'(3);
	assign sum_c        = psum_e + SUM_W'(item_s1.data_byte);
	assign last_c       = (row_e == h_m1_q) && (col_e == w_m1_q);
	assign col_ext      = 32'(col_e);
	assign row_ext      = 32'(row_e);

	// Advance the parse by one byte
	always_comb begin
		phase_d  = phase_e;
		hcount_d = hcount_e;
		img_w_d  = img_w_e;
		img_h_d  = img_h_e;
		rbc_d    = rbc_e;
		row_d    = row_e;
		col_d    = col_e;
		pbi_d    = pbi_e;
		psum_d   = psum_e;
		active_d = active_q;
		pad_m1_d = pad_m1_q;
		w_m1_d   = w_m1_q;
		h_m1_d   = h_m1_q;
		emit     = 1'b0;
		res_c    = '0;
		unique case (phase_e)
			PH_HEADER: begin
				if (hcount_e >= HCNT_W'(WIDTH_AT) && hcount_e < HCNT_W'(WIDTH_AT + 4)) begin
					img_w_d = img_w_e | byte_shifted;
				end else if (hcount_e >= HCNT_W'(HEIGHT_AT) &&
						hcount_e < HCNT_W'(HEIGHT_AT + 4)) begin
					img_h_d = img_h_e | byte_shifted;
				end
				if (hcount_e == HCNT_W'(HDR_BYTES - 1)) begin
					if (dims_ok) begin
						phase_d  = PH_PIXELS;
						active_d = active_c;
						pad_m1_d = padded_c - ACT_W'(1);
						w_m1_d   = w_dim - WID_W'(1);
						h_m1_d   = h_dim - HGT_W'(1);
					end else begin
						phase_d    = PH_DONE;
						emit       = 1'b1;
						res_c.kind = KIND_REJECT;
					end
				end else begin
					hcount_d = hcount_e + HCNT_W'(1);
				end
			end
			PH_PIXELS: begin
				if (rbc_e < active_q) begin
					if (pbi_e == 2'd2) begin
						emit             = 1'b1;
						res_c.kind       = KIND_PIXEL;
						res_c.pixel_on   = (sum_c >= threshold_q);
						res_c.column     = col_ext[POS_W-1:0];
						res_c.row        = row_ext[POS_W-1:0];
						res_c.last_pixel = last_c;
						pbi_d            = '0;
						psum_d           = '0;
						col_d            = col_e + WID_W'(1);
					end else begin
						pbi_d  = pbi_e + 2'd1;
						psum_d = sum_c;
					end
				end
				if (emit && last_c) begin
					phase_d = PH_DONE;
				end else if (rbc_e == pad_m1_q) begin
					rbc_d  = '0;
					row_d  = row_e + HGT_W'(1);
					col_d  = '0;
					pbi_d  = '0;
					psum_d = '0;
				end else begin
					rbc_d = rbc_e + ACT_W'(1);
				end
			end
			default: begin
				// Done, and the unused code: drop the byte
			end
		endcase
	end

	// Take the byte when its result, if any, has room
	assign consume   = item_valid_s1 && (!emit || out_free);
	assign res_valid = item_valid_s1 && emit;
	assign res       = res_c;

	// Commit the parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hcount_q <= '0;
			img_w_q  <= '0;
			img_h_q  <= '0;
			rbc_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			pbi_q    <= '0;
			psum_q   <= '0;
		end else if (consume) begin
			phase_q  <= phase_d;
			hcount_q <= hcount_d;
			img_w_q  <= img_w_d;
			img_h_q  <= img_h_d;
			rbc_q    <= rbc_d;
			row_q    <= row_d;
			col_q    <= col_d;
			pbi_q    <= pbi_d;
			psum_q   <= psum_d;
		end
	end

	// Hold the image geometry
	always_ff @(posedge clk) begin
		if (consume) begin
			active_q <= active_d;
			pad_m1_q <= pad_m1_d;
			w_m1_q   <= w_m1_d;
			h_m1_q   <= h_m1_d;
		end
	end

endmodule

[hw/rtl/bsb_out_reg.sv]
// Result register: holds one result until the receiver takes it.
module bsb_out_reg
	import bsb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    out_free,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_res
);

	logic    valid_q;
	result_t res_q;

	// Room when empty or when the held result transfers this cycle
	assign out_free  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Capture a new result
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

[hw/rtl/bmp24_stream_binarizer.sv]
// Top level of the 24-bit BMP stream binarizer.
//
// Bytes of a 24-bit BMP file enter on the input channel (in_valid, in_stall,
// data_byte, start_of_file), one per transfer. start_of_file on a byte
// restarts the parse with that byte as header byte 0. The 54-byte header
// yields width and height; a bad size gives one reject result (kind 1) at
// header byte 53. Each pixel then gives one result on the output channel
// (out_valid, out_stall, kind, pixel_on, column, row, last_pixel) in file
// order; row padding and bytes after the image give none.
// threshold_we/threshold_wdata write the threshold; the user must write it only
// while idle, and the block does not enforce this. A byte passes the input
// register, then the parse step into the result register. Throughput is one
// byte per cycle while a byte that gives a result is not held by out_stall.
// Reset clears the parse to header byte 0, empties both registers and sets
// the threshold to 100. While out_stall holds a result, one more byte is
// taken into the input register; bytes that give no result keep flowing,
// and a byte that gives a result waits there, stalling the input.
module bmp24_stream_binarizer
	import bsb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              threshold_we,
	input  logic [THR_W-1:0]  threshold_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              start_of_file,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic              pixel_on,
	output logic [POS_W-1:0]  column,
	output logic [POS_W-1:0]  row,
	output logic              last_pixel
);

	item_t   in_item;
	item_t   item_s1;
	logic    item_valid_s1;
	logic    consume;
	logic    out_free;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign in_item.data_byte     = data_byte;
	assign in_item.start_of_file = start_of_file;

	bsb_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_item       (in_item),
		.consume       (consume),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	bsb_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.threshold_we    (threshold_we),
		.threshold_wdata (threshold_wdata),
		.item_valid_s1   (item_valid_s1),
		.item_s1         (item_s1),
		.out_free        (out_free),
		.consume         (consume),
		.res_valid       (res_valid),
		.res             (res)
	);

	bsb_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid && consume),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign kind       = out_res.kind;
	assign pixel_on   = out_res.pixel_on;
	assign column     = out_res.column;
	assign row        = out_res.row;
	assign last_pixel = out_res.last_pixel;

endmodule
